// ===== rtl/core/shfp_pkg.sv =====
// Shared types, constants and helpers of the SimHash text fingerprint core.
`default_nettype none

package shfp_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned FP_W   = 32;

  // Significant bits of the values handed to the remainder unit
  localparam logic [CNT_W-1:0] TERM_BITS  = 7'd40;
  localparam logic [CNT_W-1:0] SUM_BITS   = 7'd33;
  localparam logic [CNT_W-1:0] POWER_BITS = 7'd64;

  // Token delimiters
  localparam logic [7:0] SEP_SPACE    = 8'h20;
  localparam logic [7:0] SEP_PERIOD   = 8'h2E;
  localparam logic [7:0] SEP_EXCLAIM  = 8'h21;
  localparam logic [7:0] SEP_QUESTION = 8'h3F;

  // Configuration register indexes
  localparam logic CFG_HASH_BASE    = 1'b0;
  localparam logic CFG_HASH_MODULUS = 1'b1;

  localparam logic [HASH_W-1:0] HASH_BASE_RST    = 32'd131;
  localparam logic [HASH_W-1:0] HASH_MODULUS_RST = 32'd4294967291;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_GO_T,
    ST_RED_T,
    ST_GO_S,
    ST_RED_S,
    ST_GO_P,
    ST_RED_P,
    ST_CLOSE,
    ST_EMIT
  } shfp_state_e;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } red_req_t;

  typedef struct packed {
    logic upd;
    logic clr;
  } vote_ctrl_t;

  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    case (c) inside
      SEP_SPACE, SEP_PERIOD, SEP_EXCLAIM, SEP_QUESTION: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/shfp_if.sv =====
// Valid/ready channel interfaces for text bytes and fingerprints.
`default_nettype none

interface shfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface shfp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] fingerprint;

  modport source (output valid, output fingerprint, input ready);
  modport sink   (input valid, input fingerprint, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/simhash_text_fingerprint_core.sv =====
// Top level of the SimHash text fingerprint core.
// Text enters one byte per item on in_i (text_byte, end_of_text); one
// fingerprint item leaves on out_o for every byte marked end_of_text.
// Configuration (hash_base index 0, hash_modulus index 1) is to be written through
// cfg_we_i/cfg_idx_i/cfg_data_i only while the core is idle; the core itself does
// not enforce this. Writes act from the next byte on.
// Each byte is worked on alone; in_i.ready is high only when idle.
// Token bytes use one 32x32 multiplier that feeds a shared bit-serial
// remainder unit, run over 40 significant bits for the term, 33 for the
// running sum and 64 for the next base power.
// The end-of-text byte also passes through the output load, and through the
// final vote when it is a token byte.
// With modulus zero the remainder unit bypasses its bit-serial steps.
// Reset restores the register defaults, clears all votes and the open token.
// The fingerprint sits in an output register; the core keeps taking bytes
// while it waits, and stalls only when a second fingerprint is ready before
// the first has been taken.
`default_nettype none

module simhash_text_fingerprint_core
  import shfp_pkg::*;
#(
  parameter int unsigned SIG_BITS  = 32,
  parameter int unsigned VOTE_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  shfp_in_if.sink                in_i,
  shfp_out_if.source             out_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [HASH_W-1:0] cfg_data_i
);

  shfp_state_e state_q, state_d;

  logic [HASH_W-1:0] base_q, mod_q;
  logic [HASH_W-1:0] th_q, bp_q;
  logic              in_tok_q;
  logic [7:0]        c_q;
  logic              last_q;
  logic [PROD_W-1:0] prod_q;
  logic              out_vld_q;
  logic [FP_W-1:0]   fp_q;

  logic              accept;
  logic              sep;
  logic              slot_free;
  logic [HASH_W-1:0] mul_a, mul_b;
  logic [HASH_W:0]   sum;

  red_req_t          red_req;
  logic [PROD_W-1:0] red_x;
  logic              red_done;
  logic [HASH_W-1:0] red_res;

  vote_ctrl_t        vote_ctrl;
  logic [FP_W-1:0]   fp;

  assign accept    = in_i.valid && in_i.ready;
  assign sep       = is_sep(in_i.text_byte);
  assign slot_free = !out_vld_q || out_o.ready;
  assign sum       = {1'b0, th_q} + {1'b0, red_res};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = sep ? ST_CLOSE : ST_MUL_T;
      ST_MUL_T: state_d = ST_GO_T;
      ST_GO_T:  state_d = ST_RED_T;
      ST_RED_T: if (red_done) state_d = ST_GO_S;
      ST_GO_S:  state_d = ST_RED_S;
      ST_RED_S: if (red_done) state_d = ST_GO_P;
      ST_GO_P:  state_d = ST_RED_P;
      ST_RED_P: if (red_done) state_d = last_q ? ST_CLOSE : ST_IDLE;
      ST_CLOSE: state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    in_i.ready    = 1'b0;
    red_req.start = 1'b0;
    red_req.nbits = POWER_BITS;
    red_x         = prod_q;
    mul_a         = bp_q;
    mul_b         = base_q;
    vote_ctrl.upd = 1'b0;
    vote_ctrl.clr = 1'b0;
    case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_MUL_T: begin
        mul_a = {24'b0, c_q};
        mul_b = bp_q;
      end
      ST_GO_T: begin
        red_req.start = 1'b1;
        red_req.nbits = TERM_BITS;
      end
      ST_GO_S: begin
        red_req.start = 1'b1;
        red_req.nbits = SUM_BITS;
        red_x         = {31'b0, sum};
      end
      ST_GO_P: red_req.start = 1'b1;
      ST_CLOSE: vote_ctrl.upd = in_tok_q;
      ST_EMIT: vote_ctrl.clr = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      base_q    <= HASH_BASE_RST;
      mod_q     <= HASH_MODULUS_RST;
      in_tok_q  <= 1'b0;
      th_q      <= '0;
      out_vld_q <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HASH_BASE:    base_q <= cfg_data_i;
          CFG_HASH_MODULUS: mod_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        last_q <= in_i.end_of_text;
        if (!sep && !in_tok_q) begin
          in_tok_q <= 1'b1;
          th_q     <= '0;
        end
      end
      if (state_q == ST_RED_S && red_done) th_q <= red_res;
      if (state_q == ST_CLOSE) begin
        in_tok_q <= 1'b0;
        th_q     <= '0;
      end
      if (state_q == ST_EMIT && slot_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q <= in_i.text_byte;
      // reload the power at token start; the product reduction absorbs it
      if (!sep && !in_tok_q) bp_q <= base_q;
    end
    if (state_q == ST_RED_P && red_done) bp_q <= red_res;
    if (state_q == ST_MUL_T || state_q == ST_GO_S) prod_q <= mul_a * mul_b;
    if (state_q == ST_EMIT && slot_free) fp_q <= fp;
  end

  shfp_mod_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (red_req),
    .x_i    (red_x),
    .mod_i  (mod_q),
    .done_o (red_done),
    .res_o  (red_res)
  );

  shfp_votes #(
    .SIG_BITS  (SIG_BITS),
    .VOTE_BITS (VOTE_BITS)
  ) u_votes (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (vote_ctrl),
    .hash_i (th_q),
    .fp_o   (fp)
  );

  assign out_o.valid       = out_vld_q;
  assign out_o.fingerprint = fp_q;

endmodule

`default_nettype wire

// ===== rtl/core/shfp_mod_reduce.sv =====
// Bit-serial restoring remainder unit: value mod modulus, one bit per cycle.
`default_nettype none

module shfp_mod_reduce
  import shfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire red_req_t          req_i,
  input  wire logic [PROD_W-1:0] x_i,
  input  wire logic [HASH_W-1:0] mod_i,
  output logic                   done_o,
  output logic [HASH_W-1:0]      res_o
);

  logic [HASH_W-1:0] r_q, r_d;
  logic [PROD_W-1:0] x_q, x_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [HASH_W:0]   trial;
  logic [HASH_W:0]   diff;
  logic [CNT_W-1:0]  lshift;

  always_comb begin
    trial  = {r_q, x_q[PROD_W-1]};
    diff   = trial - {1'b0, mod_i};
    lshift = POWER_BITS - req_i.nbits;
    r_d    = r_q;
    x_d    = x_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      if (mod_i == '0) begin
        // modulus zero stands for 2^32: plain wrap
        r_d    = x_i[HASH_W-1:0];
        done_d = 1'b1;
      end else begin
        // align the significant bits to the top
        r_d    = '0;
        x_d    = x_i << lshift;
        cnt_d  = req_i.nbits;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      r_d   = (trial >= {1'b0, mod_i}) ? diff[HASH_W-1:0] : trial[HASH_W-1:0];
      x_d   = {x_q[PROD_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/shfp_votes.sv =====
// Bank of saturating signed vote counters, one per signature bit.
`default_nettype none

module shfp_votes
  import shfp_pkg::*;
#(
  parameter int unsigned SIG_BITS  = 32,
  parameter int unsigned VOTE_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire vote_ctrl_t        ctrl_i,
  input  wire logic [HASH_W-1:0] hash_i,
  output logic [FP_W-1:0]        fp_o
);

  localparam logic signed [VOTE_BITS-1:0] VoteMax = {1'b0, {(VOTE_BITS-1){1'b1}}};
  localparam logic signed [VOTE_BITS-1:0] VoteMin = {1'b1, {(VOTE_BITS-1){1'b0}}};
  localparam logic signed [VOTE_BITS-1:0] VoteOne = {{(VOTE_BITS-1){1'b0}}, 1'b1};

  logic signed [VOTE_BITS-1:0] vote_q [SIG_BITS];
  logic [SIG_BITS-1:0]         hbit;

  for (genvar j = 0; j < SIG_BITS; j++) begin : g_lane
    if (j < HASH_W) begin : g_hash
      assign hbit[j] = hash_i[j];
    end else begin : g_zero
      // hash has no bit here: vote only goes down
      assign hbit[j] = 1'b0;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vote_q[j] <= '0;
      end else if (ctrl_i.clr) begin
        vote_q[j] <= '0;
      end else if (ctrl_i.upd) begin
        if (hbit[j]) begin
          if (vote_q[j] != VoteMax) vote_q[j] <= vote_q[j] + VoteOne;
        end else begin
          if (vote_q[j] != VoteMin) vote_q[j] <= vote_q[j] - VoteOne;
        end
      end
    end
  end

  for (genvar k = 0; k < FP_W; k++) begin : g_fp
    if (k < SIG_BITS) begin : g_bit
      assign fp_o[k] = !vote_q[k][VOTE_BITS-1] && (vote_q[k] != '0);
    end else begin : g_pad
      assign fp_o[k] = 1'b0;
    end
  end

endmodule

`default_nettype wire
